// ===== src/pi3w_pkg.sv =====
// ----------------------------------------------------------------------------
// pi3w_pkg: shared types and constants for the three-mode PI controller
// Holds the payload structs of both channels, the command codes, the
// configuration register indexes and the fixed per-mode limits.
// ----------------------------------------------------------------------------
package pi3w_pkg;

    // Command codes carried in the input beat
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_PUSH   = 2'd1;
    localparam logic [1:0] CMD_RESET  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_GAINS_START  = 3'd0;
    localparam logic [2:0] REG_GAINS_PUSH   = 3'd1;
    localparam logic [2:0] REG_GAINS_RESET  = 3'd2;
    localparam logic [2:0] REG_LIMIT_START  = 3'd3;
    localparam logic [2:0] REG_LIMIT_PUSH   = 3'd4;
    localparam logic [2:0] REG_WINDOW_RESET = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Datapath widths
    localparam int ERR_W  = 25;   // setpoint - feedback
    localparam int INTG_W = 25;   // stored Q.8 integral
    localparam int ACC_W  = 42;   // products and sums
    localparam int FRAC_W = 8;    // Q.8 fraction bits

    // Integration windows, integral clamp of reset mode (output units)
    localparam logic [ERR_W-1:0] WIN_START       = 25'd300;
    localparam logic [ERR_W-1:0] WIN_PUSH        = 25'd8000;
    localparam logic [15:0]      INT_CLAMP_RESET = 16'd1000;

    // Output limits
    localparam logic signed [14:0] OUT_LIM_START = 15'sd8000;
    localparam logic signed [14:0] OUT_LIM_PUSH  = 15'sd16000;
    localparam logic signed [14:0] OUT_LIM_RESET = 15'sd6000;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [23:0] feedback;
        logic signed [23:0] setpoint;
    } in_beat_t;

    typedef struct packed {
        logic signed [14:0] drive;
        logic               out_clipped;
    } out_beat_t;

endpackage

// ===== src/three_mode_pi_with_integral_window_top.sv =====
// ----------------------------------------------------------------------------
// three_mode_pi_with_integral_window_top: three-mode PI current controller
// Each input beat names a mode (start, push, reset) and carries setpoint and
// feedback. The block forms the error, a proportional term, a windowed and
// clamped per-mode integral, and a saturated drive value with a clip flag.
//
// Use:
//   s_valid/s_ready/s_data  input beats (command, feedback, setpoint).
//   m_valid/m_ready/m_data  result beats (drive, out_clipped), one per input.
//   cfg_we/cfg_index/cfg_wdata  gain, clamp and window registers; write
//   them only while no beat is in flight.
// Path: a beat accepted into the input register has its result captured
//   in the result register and presented on m_valid (two-register path).
// Throughput: one beat per cycle unless m_ready stalls a held result.
//   The whole computation (two 25x17 multiplies, integral add and clamp,
//   sum and saturation) sits between the input register and the result
//   register, and the per-mode integral is read and written in the same
//   cycle, so consecutive beats of one mode chain without a gap.
// Reset: aresetn (synchronous, active low) clears the valid flags, all
//   configuration registers and all three integrals.
// Stall: while m_ready is low and a result is held, the input register
//   keeps one beat and s_ready drops once it is occupied; nothing is lost.
// ----------------------------------------------------------------------------
module three_mode_pi_with_integral_window_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  pi3w_pkg::in_beat_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pi3w_pkg::out_beat_t                 m_data,
    input  logic                                cfg_we,
    input  logic [pi3w_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pi3w_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pi3w_pkg::*;

    // Configuration registers
    logic [31:0] gains_start_reg, gains_push_reg, gains_reset_reg;
    logic [15:0] limit_start_reg, limit_push_reg, window_reset_reg;

    // Pipeline registers
    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;
    out_beat_t out_data_next;

    // Per-mode integrals
    logic signed [INTG_W-1:0] integ_reg [3];
    logic signed [INTG_W-1:0] integ_next;

    // Handshake
    logic stage_adv;
    logic fire;

    // Datapath
    logic [31:0]              gains_sel;
    logic signed [16:0]       kp_s, ki_s;
    logic signed [INTG_W-1:0] integ_cur;
    logic signed [ERR_W-1:0]  err;
    logic [ERR_W-1:0]         mag;
    logic                     in_window;
    logic [15:0]              ilim_units;
    logic signed [ACC_W-1:0]  ilim, p_term, i_term, integ_sum, integ_clamped;
    logic signed [ACC_W-1:0]  sum, olim_pos, olim_neg, sum_shr;
    logic signed [14:0]       olim;
    logic                     mode_valid;

    assign stage_adv = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || stage_adv;
    assign fire      = in_valid_reg && stage_adv;

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_start_reg  <= '0;
            gains_push_reg   <= '0;
            gains_reset_reg  <= '0;
            limit_start_reg  <= '0;
            limit_push_reg   <= '0;
            window_reset_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GAINS_START:  gains_start_reg  <= cfg_wdata;
                REG_GAINS_PUSH:   gains_push_reg   <= cfg_wdata;
                REG_GAINS_RESET:  gains_reset_reg  <= cfg_wdata;
                REG_LIMIT_START:  limit_start_reg  <= cfg_wdata[15:0];
                REG_LIMIT_PUSH:   limit_push_reg   <= cfg_wdata[15:0];
                REG_WINDOW_RESET: window_reset_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Mode selection of gains, limits and the stored integral
    always_comb begin
        mode_valid = 1'b1;
        gains_sel  = gains_start_reg;
        ilim_units = limit_start_reg;
        olim       = OUT_LIM_START;
        integ_cur  = integ_reg[0];
        unique case (in_data_reg.command)
            CMD_START: begin
                gains_sel  = gains_start_reg;
                ilim_units = limit_start_reg;
                olim       = OUT_LIM_START;
                integ_cur  = integ_reg[0];
            end
            CMD_PUSH: begin
                gains_sel  = gains_push_reg;
                ilim_units = limit_push_reg;
                olim       = OUT_LIM_PUSH;
                integ_cur  = integ_reg[1];
            end
            CMD_RESET: begin
                gains_sel  = gains_reset_reg;
                ilim_units = INT_CLAMP_RESET;
                olim       = OUT_LIM_RESET;
                integ_cur  = integ_reg[2];
            end
            CMD_UNUSED: begin
                mode_valid = 1'b0;
            end
            default: begin
                mode_valid = 1'b0;
            end
        endcase
    end

    // Error, magnitude and window test
    assign err = ERR_W'(in_data_reg.setpoint) - ERR_W'(in_data_reg.feedback);
    assign mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    always_comb begin
        unique case (in_data_reg.command)
            CMD_START: in_window = (mag <= WIN_START);
            CMD_PUSH:  in_window = (mag <= WIN_PUSH);
            CMD_RESET: in_window = (mag < ERR_W'(window_reset_reg));
            default:   in_window = 1'b0;
        endcase
    end

    // Gain products (Q.8)
    assign kp_s   = {1'b0, gains_sel[31:16]};
    assign ki_s   = {1'b0, gains_sel[15:0]};
    assign p_term = err * kp_s;
    assign i_term = err * ki_s;

    // Windowed integral with clamp to +-limit
    assign ilim      = ACC_W'({ilim_units, {FRAC_W{1'b0}}});
    assign integ_sum = in_window ? (ACC_W'(integ_cur) + i_term) : '0;

    always_comb begin
        if (integ_sum > ilim) begin
            integ_clamped = ilim;
        end else if (integ_sum < -ilim) begin
            integ_clamped = -ilim;
        end else begin
            integ_clamped = integ_sum;
        end
    end

    assign integ_next = integ_clamped[INTG_W-1:0];

    // Output sum and saturation
    assign sum      = p_term + ACC_W'(integ_next);
    assign olim_pos = ACC_W'(olim) <<< FRAC_W;
    assign olim_neg = -olim_pos;
    assign sum_shr  = sum >>> FRAC_W;

    always_comb begin
        out_data_next = '0;
        if (mode_valid) begin
            priority if (sum > olim_pos) begin
                out_data_next.drive       = olim;
                out_data_next.out_clipped = 1'b1;
            end else if (sum < olim_neg) begin
                out_data_next.drive       = -olim;
                out_data_next.out_clipped = 1'b1;
            end else begin
                out_data_next.drive       = sum_shr[14:0];
                out_data_next.out_clipped = 1'b0;
            end
        end
    end

    // Integral store update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
            integ_reg[2] <= '0;
        end else if (fire) begin
            unique case (in_data_reg.command)
                CMD_START: integ_reg[0] <= integ_next;
                CMD_PUSH:  integ_reg[1] <= integ_next;
                CMD_RESET: integ_reg[2] <= integ_next;
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stage_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A clipped result always carries one of the mode limits
    a_clip_at_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.out_clipped) |->
            (m_data.drive == OUT_LIM_START || m_data.drive == -OUT_LIM_START ||
             m_data.drive == OUT_LIM_PUSH  || m_data.drive == -OUT_LIM_PUSH ||
             m_data.drive == OUT_LIM_RESET || m_data.drive == -OUT_LIM_RESET))
        else $error("clipped drive not at a mode limit");

    // Drive never exceeds the widest output limit
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.drive <= OUT_LIM_PUSH && m_data.drive >= -OUT_LIM_PUSH))
        else $error("drive out of range");

    // With no result pending the input side is never blocked
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low without a pending result");

    // Reset-mode integral stays within its fixed clamp
    a_reset_integ_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (integ_reg[2] <= INTG_W'($signed({INT_CLAMP_RESET, {FRAC_W{1'b0}}})) &&
         integ_reg[2] >= -INTG_W'($signed({INT_CLAMP_RESET, {FRAC_W{1'b0}}}))))
        else $error("reset-mode integral beyond clamp");

    // An unused command leaves every integral unchanged
    a_unused_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_data_reg.command == CMD_UNUSED) |=>
            ($stable(integ_reg[0]) && $stable(integ_reg[1]) && $stable(integ_reg[2])))
        else $error("unused command changed an integral");

endmodule

// ===== tb/drive_checker.sv =====
// ----------------------------------------------------------------------------
// drive_checker: result predictor and comparator for the three-mode PI block
// Watches the configuration port and both channels. Every accepted input
// beat is run through an independent model of the controller (per-mode
// integral, window, clamp and output saturation) and the predicted result
// is queued. Every accepted result beat is compared field by field against
// the oldest queued prediction. Failures and the queue depth go to the top.
// ----------------------------------------------------------------------------
module drive_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  pi3w_pkg::in_beat_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  pi3w_pkg::out_beat_t             m_data,
    input  logic                            cfg_we,
    input  logic [pi3w_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pi3w_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              n_fail,
    output int                              n_pending
);
    import pi3w_pkg::*;

    // Fixed controller constants
    localparam longint WINDOW_START  = 300;
    localparam longint WINDOW_PUSH   = 8000;
    localparam longint CLAMP_RESET   = 1000;
    localparam longint DRV_LIM_START = 8000;
    localparam longint DRV_LIM_PUSH  = 16000;
    localparam longint DRV_LIM_RESET = 6000;
    localparam longint Q8_ONE        = 256;

    // Shadow configuration and per-mode integrals (Q.8)
    logic [31:0] gains_sh [3];
    logic [15:0] lim_start_sh;
    logic [15:0] lim_push_sh;
    logic [15:0] win_reset_sh;
    longint      integ_sh [3];

    out_beat_t   drive_q [$];
    out_beat_t   want;

    initial begin
        n_fail    = 0;
        n_pending = 0;
    end

    // One controller step; updates the integral of the addressed mode
    function automatic out_beat_t predict_drive(in_beat_t b);
        longint    err;
        longint    mag;
        longint    kp;
        longint    ki;
        longint    ilim;
        longint    olim;
        longint    acc;
        longint    sum;
        longint    dval;
        logic [31:0] g;
        logic      in_window;
        int        m;
        out_beat_t r;
        r = '0;
        if (b.command == CMD_UNUSED) begin
            return r;
        end
        err = longint'($signed(b.setpoint)) - longint'($signed(b.feedback));
        mag = (err < 0) ? -err : err;
        m   = int'(b.command);
        case (b.command)
            CMD_START: begin
                g         = gains_sh[0];
                in_window = (mag <= WINDOW_START);
                ilim      = longint'(lim_start_sh) * Q8_ONE;
                olim      = DRV_LIM_START;
            end
            CMD_PUSH: begin
                g         = gains_sh[1];
                in_window = (mag <= WINDOW_PUSH);
                ilim      = longint'(lim_push_sh) * Q8_ONE;
                olim      = DRV_LIM_PUSH;
            end
            default: begin
                g         = gains_sh[2];
                in_window = (mag < longint'(win_reset_sh));
                ilim      = CLAMP_RESET * Q8_ONE;
                olim      = DRV_LIM_RESET;
            end
        endcase
        kp = longint'(g[31:16]);
        ki = longint'(g[15:0]);

        // windowed integral, then clamp
        acc = in_window ? (integ_sh[m] + err * ki) : 0;
        if (acc > ilim) acc = ilim;
        if (acc < -ilim) acc = -ilim;
        integ_sh[m] = acc;

        // proportional plus integral, saturate, floor to output units
        sum = err * kp + acc;
        if (sum > olim * Q8_ONE) begin
            dval          = olim;
            r.out_clipped = 1'b1;
        end else if (sum < -olim * Q8_ONE) begin
            dval          = -olim;
            r.out_clipped = 1'b1;
        end else begin
            dval = sum >>> 8;
        end
        r.drive = 15'(dval);
        return r;
    endfunction

    // Track config, compare results, queue predictions
    always @(posedge aclk) begin
        if (!aresetn) begin
            gains_sh[0]  = '0;
            gains_sh[1]  = '0;
            gains_sh[2]  = '0;
            lim_start_sh = '0;
            lim_push_sh  = '0;
            win_reset_sh = '0;
            integ_sh[0]  = 0;
            integ_sh[1]  = 0;
            integ_sh[2]  = 0;
            drive_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_GAINS_START:  gains_sh[0]  = cfg_wdata;
                    REG_GAINS_PUSH:   gains_sh[1]  = cfg_wdata;
                    REG_GAINS_RESET:  gains_sh[2]  = cfg_wdata;
                    REG_LIMIT_START:  lim_start_sh = cfg_wdata[15:0];
                    REG_LIMIT_PUSH:   lim_push_sh  = cfg_wdata[15:0];
                    REG_WINDOW_RESET: win_reset_sh = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            // result beat: a result never leaves in the cycle its input is accepted, so check before queuing
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    $error("result beat with no prediction: drive %0d out_clipped %0b",
                           $signed(m_data.drive), m_data.out_clipped);
                    n_fail++;
                end else begin
                    want = drive_q.pop_front();
                    if (m_data.drive !== want.drive) begin
                        $error("drive mismatch: expected %0d actual %0d",
                               $signed(want.drive), $signed(m_data.drive));
                        n_fail++;
                    end
                    if (m_data.out_clipped !== want.out_clipped) begin
                        $error("out_clipped mismatch: expected %0b actual %0b",
                               want.out_clipped, m_data.out_clipped);
                        n_fail++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                drive_q.push_back(predict_drive(s_data));
            end
        end
        n_pending = drive_q.size();
    end

endmodule

// ===== tb/tb_three_mode_pi_with_integral_window_top.sv =====
// ----------------------------------------------------------------------------
// tb_three_mode_pi_with_integral_window_top: stimulus and verdict
// Resets the controller, runs a directed set of window edges, clamp and
// saturation cases, then random phases under several register settings
// (reset values, all ones, all zero, zero clamps, random). Both channels get
// random gaps and stalls; some phases run flat out. The checker beside the
// block predicts and compares; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb_three_mode_pi_with_integral_window_top;
    import pi3w_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BEATS    = 190;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_beat_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int    n_fail;
    int    n_pending;
    int    idle_cycles = 0;
    int    rdy_left    = 0;
    logic  calm        = 1'b0;
    int    win_now     = 0;

    three_mode_pi_with_integral_window_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    drive_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    // 10-unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_beat_t mk_beat(logic [1:0] cmd, int fb, int sp);
        in_beat_t b;
        b.command  = cmd;
        b.feedback = 24'(fb);
        b.setpoint = 24'(sp);
        return b;
    endfunction

    // random beat: mostly errors around the mode's window, some full range
    function automatic in_beat_t rand_beat(logic [1:0] cmd);
        in_beat_t b;
        int sel;
        int span;
        int err;
        int fb;
        b.command = cmd;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            b.feedback = 24'($urandom);
            b.setpoint = 24'($urandom);
        end else begin
            case (cmd)
                CMD_START: span = 320;
                CMD_PUSH:  span = 8100;
                default:   span = win_now + 20;
            endcase
            if (sel >= 80) span = 40000;
            err = int'($urandom_range(0, 2 * span)) - span;
            fb  = int'($urandom_range(0, 8000000)) - 4000000;
            b.feedback = 24'(fb);
            b.setpoint = 24'(fb + err);
        end
        return b;
    endfunction

    function automatic logic [31:0] rand_gain();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) return $urandom;
        return {16'($urandom_range(0, 2048)), 16'($urandom_range(0, 1024))};
    endfunction

    function automatic logic [15:0] rand_lim();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 20) return 16'($urandom);
        if (sel < 25) return 16'd0;
        if (sel < 30) return 16'hFFFF;
        return 16'($urandom_range(0, 3000));
    endfunction

    // drive one input beat and hold it until accepted
    task automatic send_beat(in_beat_t b);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop sending and wait for every predicted result to come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // write all six registers back to back; block must be idle
    task automatic load_setup(logic [31:0] g_start, logic [31:0] g_push,
                              logic [31:0] g_reset, logic [15:0] l_start,
                              logic [15:0] l_push, logic [15:0] w_reset);
        logic [31:0] vals [6];
        vals[REG_GAINS_START]  = g_start;
        vals[REG_GAINS_PUSH]   = g_push;
        vals[REG_GAINS_RESET]  = g_reset;
        vals[REG_LIMIT_START]  = {16'd0, l_start};
        vals[REG_LIMIT_PUSH]   = {16'd0, l_push};
        vals[REG_WINDOW_RESET] = {16'd0, w_reset};
        for (int i = 0; i < 6; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
        end
        @(negedge aclk);
        cfg_we  <= 1'b0;
        win_now  = int'(w_reset);
    endtask

    // result side: random stalls, or always ready in calm phases
    always @(negedge aclk) begin
        if (rdy_left > 0) begin
            rdy_left <= rdy_left - 1;
        end else if (calm) begin
            m_ready  <= 1'b1;
            rdy_left <= $urandom_range(0, 8);
        end else if ($urandom_range(0, 99) < 65) begin
            m_ready  <= 1'b1;
            rdy_left <= $urandom_range(0, 6);
        end else begin
            m_ready  <= 1'b0;
            rdy_left <= pick_gap();
        end
    end

    // watchdog: cycles without any beat moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_three_mode_pi_with_integral_window_top NOT OK");
            $finish;
        end
    end

    initial begin
        int         n;
        int         burst;
        logic [1:0] cmd;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // registers at reset values: everything should come out zero
        for (int i = 0; i < 20; i++) begin
            send_beat(rand_beat(2'($urandom_range(0, 3))));
        end
        drain_results();

        // directed: window edges, clamp, exact limit, extremes, rounding
        load_setup({16'd256, 16'd128}, {16'd256, 16'd512}, {16'd256, 16'd64},
                   16'd100, 16'd2000, 16'd500);
        send_beat(mk_beat(CMD_START, 0, 0));
        send_beat(mk_beat(CMD_START, 0, 300));
        send_beat(mk_beat(CMD_START, 0, 300));
        send_beat(mk_beat(CMD_START, 0, 301));
        send_beat(mk_beat(CMD_START, 300, 0));
        send_beat(mk_beat(CMD_START, 301, 0));
        send_beat(mk_beat(CMD_START, 0, 8000));
        send_beat(mk_beat(CMD_START, 0, 8001));
        send_beat(mk_beat(CMD_START, 8000, 0));
        send_beat(mk_beat(CMD_START, 8001, 0));
        send_beat(mk_beat(CMD_PUSH, -100, 7900));
        send_beat(mk_beat(CMD_PUSH, 0, 8001));
        send_beat(mk_beat(CMD_PUSH, 8000, 0));
        send_beat(mk_beat(CMD_RESET, 1, 500));
        send_beat(mk_beat(CMD_RESET, 0, 500));
        send_beat(mk_beat(CMD_RESET, 499, 0));
        send_beat(mk_beat(CMD_RESET, 6001, 0));
        send_beat(mk_beat(CMD_UNUSED, -8388608, 8388607));
        send_beat(mk_beat(CMD_PUSH, -8388608, 8388607));
        send_beat(mk_beat(CMD_PUSH, 8388607, -8388608));
        send_beat(mk_beat(CMD_START, 8388607, 8388607));
        send_beat(mk_beat(CMD_RESET, -8388608, -8388608));
        send_beat(mk_beat(CMD_START, 1, 0));
        send_beat(mk_beat(CMD_UNUSED, 0, 0));

        // random phases under different settings
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            case (ph)
                0: load_setup('1, '1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: load_setup(rand_gain(), rand_gain(), rand_gain(), 16'd0, 16'd0, 16'd0);
                2: load_setup('0, '0, '0, 16'd0, 16'd0, 16'd0);
                default: load_setup(rand_gain(), rand_gain(), rand_gain(),
                                    rand_lim(), rand_lim(), rand_lim());
            endcase
            calm = (ph % 3 == 1);
            n = 0;
            // bursts of one mode so integrals build up and hit the clamp
            while (n < PHASE_BEATS) begin
                cmd   = ($urandom_range(0, 99) < 6) ? CMD_UNUSED
                                                    : 2'($urandom_range(0, 2));
                burst = $urandom_range(1, 12);
                for (int j = 0; j < burst && n < PHASE_BEATS; j++) begin
                    send_beat(rand_beat(cmd));
                    n++;
                end
            end
        end

        drain_results();
        repeat (8) @(negedge aclk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("tb_three_mode_pi_with_integral_window_top OK");
        end else begin
            $display("tb_three_mode_pi_with_integral_window_top NOT OK");
        end
        $finish;
    end

endmodule
